### src/brj_pkg.sv
// Shared types and constants of the bearing residual and Jacobian block.
// Used by the top level; depends on nothing.
`timescale 1ns / 1ps

package brj_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;
  localparam int unsigned FIELD_W        = 32;

  typedef enum logic {
    FUNC_POSE = 1'b0,
    FUNC_OBS  = 1'b1
  } func_e;

  localparam logic [1:0] POSE_ROWS = 2'd3;
  localparam logic [1:0] ROW_FIRST = 2'd0;
  localparam logic [1:0] ROW_MID   = 2'd1;
  localparam logic [1:0] ROW_LAST  = 2'd2;

  typedef logic signed [FIELD_W-1:0] field_t;

  typedef struct packed {
    func_e      func;
    logic [1:0] pose_row;
    field_t     rot_a;
    field_t     rot_b;
    field_t     rot_c;
    field_t     trans;
    field_t     landmark_x;
    field_t     landmark_y;
    field_t     landmark_z;
    field_t     dir_x;
    field_t     dir_y;
    field_t     dir_z;
  } obs_t;

  typedef struct packed {
    logic [1:0] row_index;
    field_t     err_value;
    field_t     jac_0;
    field_t     jac_1;
    field_t     jac_2;
    field_t     jac_3;
    field_t     jac_4;
    field_t     jac_5;
    field_t     jac_6;
    field_t     jac_7;
    field_t     jac_8;
    logic       last_row;
  } res_t;

endpackage

### src/brj_stream_if.sv
// Valid/ready stream channel carrying one payload of type T per transaction.
// Payload types come from brj_pkg.
`timescale 1ns / 1ps

interface brj_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/bearing_residual_jacobian.sv
// Bearing residual and 3x9 Jacobian pipeline for bundle adjustment.
// Depends on brj_pkg and brj_stream_if.
//
// Usage:
//   obs_i takes transactions of brj_pkg::obs_t. func = FUNC_POSE writes one pose
//   row (three rotation entries and a translation) into the pose store and gives
//   no result; a row number of three is dropped. func = FUNC_OBS sends one
//   landmark and direction through the pipeline with the pose stored at that time.
//   res_o gives three transactions of brj_pkg::res_t per observation, rows 0, 1, 2,
//   last_row set on row 2.
// The square root takes one stage per root bit and the two dividers one per
//   quotient bit. Values are W = min(DATA_WIDTH, 32) bits wide, F = FRAC_BITS.
// The output row serializer gives the three rows of an observation in turn; the
//   pipeline takes new observations while earlier ones are still in flight.
// Reset clears the pose store to zero and empties the pipeline.
// When res_o stalls, the pipeline keeps advancing until a transaction sits in its
//   last stage and then holds as a whole; obs_i.ready drops only while the last
//   stage and the serializer are full.
`timescale 1ns / 1ps

module bearing_residual_jacobian #(
  parameter int unsigned DATA_WIDTH = brj_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = brj_pkg::FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  brj_stream_if.sink   obs_i,
  brj_stream_if.source res_o
);

  localparam int unsigned W     = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam int unsigned F     = FRAC_BITS;
  localparam int unsigned SATW  = 2 * W + F + 4;
  localparam int unsigned UREMW = W + F;
  localparam int unsigned QU    = F + 1;
  localparam int unsigned UPW   = 2 * F + 4;
  localparam int unsigned JW    = ((2 * F + 2 > 2 * W) ? 2 * F + 2 : 2 * W) + 1;

  typedef logic signed [W-1:0]   val_t;
  typedef logic signed [2*W-1:0] wide_t;
  typedef logic signed [F+2:0]   nw_t;

  localparam val_t VMAX = {1'b0, {(W-1){1'b1}}};
  localparam val_t VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [UPW-1:0] ONE_UP = UPW'(1) << F;

  typedef struct packed {
    logic [W-1:0] n;
    val_t [2:0]   p;
    val_t [2:0]   d;
    val_t [8:0]   rot;
  } carry_t;

  typedef struct packed {
    val_t [8:0] rot;
    val_t [2:0] t;
    val_t [2:0] l;
    val_t [2:0] d;
  } a_t;

  typedef struct packed {
    wide_t [8:0] pr;
    val_t  [2:0] t;
    val_t  [2:0] d;
    val_t  [8:0] rot;
  } b_t;

  typedef struct packed {
    logic [2:0][2*W-1:0] sq;
    carry_t              c;
  } d_t;

  typedef struct packed {
    logic [2*W-1:0] n2;
    logic [W+1:0]   rem;
    logic [W-1:0]   root;
    carry_t         c;
  } sq_t;

  typedef struct packed {
    logic [2:0][UREMW-1:0] rem;
    logic [2:0][F:0]       q;
    logic [2:0]            neg;
    carry_t                c;
  } ud_t;

  typedef struct packed {
    nw_t  [8:0] num;
    val_t [2:0] err;
    carry_t     c;
  } g_t;

  typedef struct packed {
    logic [8:0][JW-1:0] rem;
    logic [8:0][W-1:0]  q;
    logic [8:0]         neg;
    logic [8:0]         ovf;
    val_t [2:0]         err;
    carry_t             c;
  } jd_t;

  typedef struct packed {
    val_t [8:0] jn;
    val_t [2:0] err;
    val_t [2:0] p;
    val_t [8:0] rot;
  } i_t;

  typedef struct packed {
    val_t  [8:0]  jn;
    val_t  [2:0]  err;
    wide_t [8:0]  ra;
    wide_t [8:0]  rb;
    wide_t [26:0] lp;
  } j_t;

  typedef struct packed {
    val_t [2:0] err;
    val_t [8:0] jn;
    val_t [8:0] jr;
    val_t [8:0] jl;
  } k_t;

  function automatic val_t sat_w(input logic signed [SATW-1:0] v);
    logic signed [SATW-1:0] mx;
    logic signed [SATW-1:0] mn;
    mx = {{(SATW-W+1){1'b0}}, {(W-1){1'b1}}};
    mn = ~mx;
    if (v > mx) begin
      return VMAX;
    end else if (v < mn) begin
      return VMIN;
    end
    return val_t'(v[W-1:0]);
  endfunction

  function automatic wide_t mulq(input val_t a, input val_t b);
    wide_t pr;
    pr = a * b;
    return pr >>> F;
  endfunction

  function automatic sq_t sqrt_step(input sq_t s, input int unsigned i);
    sq_t          o;
    logic [W+1:0] rsh;
    logic [W+1:0] trial;
    o     = s;
    rsh   = {s.rem[W-1:0], s.n2[2*i+1 -: 2]};
    trial = {s.root, 2'b01};
    if (rsh >= trial) begin
      o.rem  = rsh - trial;
      o.root = {s.root[W-2:0], 1'b1};
    end else begin
      o.rem  = rsh;
      o.root = {s.root[W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic ud_t udiv_step(input ud_t s, input int unsigned b);
    ud_t            o;
    logic [UREMW-1:0] dv;
    o  = s;
    dv = UREMW'(s.c.n) << b;
    for (int i = 0; i < 3; i++) begin
      if (s.rem[i] >= dv) begin
        o.rem[i]  = s.rem[i] - dv;
        o.q[i][b] = 1'b1;
      end
    end
    return o;
  endfunction

  function automatic jd_t jdiv_step(input jd_t s, input int unsigned b);
    jd_t           o;
    logic [JW-1:0] dv;
    o  = s;
    dv = JW'(s.c.n) << b;
    for (int e = 0; e < 9; e++) begin
      if (s.rem[e] >= dv) begin
        o.rem[e]  = s.rem[e] - dv;
        o.q[e][b] = 1'b1;
      end
    end
    return o;
  endfunction

  // Flow control
  logic       en;
  logic       ser_load;
  logic       obs_acc;
  logic       ser_v_q;
  logic [1:0] ser_row_q;
  k_t         ser_q;
  logic       k_v_q;
  k_t         k_q;

  assign ser_load    = !ser_v_q || (res_o.ready && ser_row_q == brj_pkg::ROW_LAST);
  assign en          = !k_v_q || ser_load;
  assign obs_i.ready = en;
  assign obs_acc     = obs_i.valid && en;

  // Pose store
  val_t [11:0] pose_q;
  val_t [11:0] pose_d;

  always_comb begin
    pose_d = pose_q;
    if (obs_acc && obs_i.data.func == brj_pkg::FUNC_POSE &&
        obs_i.data.pose_row != brj_pkg::POSE_ROWS) begin
      for (int r = 0; r < 3; r++) begin
        if (obs_i.data.pose_row == 2'(r)) begin
          pose_d[r*4+0] = sat_w(SATW'(obs_i.data.rot_a));
          pose_d[r*4+1] = sat_w(SATW'(obs_i.data.rot_b));
          pose_d[r*4+2] = sat_w(SATW'(obs_i.data.rot_c));
          pose_d[r*4+3] = sat_w(SATW'(obs_i.data.trans));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_q <= '0;
    end else begin
      pose_q <= pose_d;
    end
  end

  // Stage A: capture observation with the current pose
  logic a_v_q;
  a_t   a_q;
  a_t   a_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        a_d.rot[i*3+j] = pose_q[i*4+j];
      end
      a_d.t[i] = pose_q[i*4+3];
    end
    a_d.l[0] = sat_w(SATW'(obs_i.data.landmark_x));
    a_d.l[1] = sat_w(SATW'(obs_i.data.landmark_y));
    a_d.l[2] = sat_w(SATW'(obs_i.data.landmark_z));
    a_d.d[0] = sat_w(SATW'(obs_i.data.dir_x));
    a_d.d[1] = sat_w(SATW'(obs_i.data.dir_y));
    a_d.d[2] = sat_w(SATW'(obs_i.data.dir_z));
  end

  // Stage B: rotation products
  logic b_v_q;
  b_t   b_q;
  b_t   b_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        b_d.pr[i*3+j] = mulq(a_q.rot[i*3+j], a_q.l[j]);
      end
    end
    b_d.t   = a_q.t;
    b_d.d   = a_q.d;
    b_d.rot = a_q.rot;
  end

  // Stage C: camera-frame point
  logic   c_v_q;
  carry_t c_q;
  carry_t c_d;

  always_comb begin
    c_d.n = '0;
    for (int i = 0; i < 3; i++) begin
      c_d.p[i] = sat_w(SATW'(b_q.t[i]) + SATW'(b_q.pr[i*3]) + SATW'(b_q.pr[i*3+1]) +
                       SATW'(b_q.pr[i*3+2]));
    end
    c_d.d   = b_q.d;
    c_d.rot = b_q.rot;
  end

  // Stage D: squares
  logic d_v_q;
  d_t   d_q;
  d_t   d_d;

  always_comb begin
    wide_t sqs;
    for (int i = 0; i < 3; i++) begin
      sqs       = c_q.p[i] * c_q.p[i];
      d_d.sq[i] = $unsigned(sqs);
    end
    d_d.c = c_q;
  end

  // Square root chain, one root bit per stage
  logic [W:0] sq_v_q;
  sq_t        sq_q [W+1];
  sq_t        sq0_d;

  always_comb begin
    sq0_d.n2   = d_q.sq[0] + d_q.sq[1] + d_q.sq[2];
    sq0_d.rem  = '0;
    sq0_d.root = '0;
    sq0_d.c    = d_q.c;
  end

  // Divider chain for the unit vector, one quotient bit per stage
  logic [QU:0] ud_v_q;
  ud_t         ud_q [QU+1];
  ud_t         ud0_d;

  always_comb begin
    logic [W-1:0] mag;
    ud0_d.c   = sq_q[W].c;
    ud0_d.c.n = sq_q[W].root;
    ud0_d.q   = '0;
    for (int i = 0; i < 3; i++) begin
      ud0_d.neg[i] = sq_q[W].c.p[i][W-1];
      mag          = ud0_d.neg[i] ? W'(-sq_q[W].c.p[i]) : W'(sq_q[W].c.p[i]);
      ud0_d.rem[i] = UREMW'(mag) << F;
    end
  end

  // Stage G: error and projector numerators
  logic g_v_q;
  g_t   g_q;
  g_t   g_d;

  always_comb begin
    logic signed [F+1:0]  uv [3];
    logic signed [UPW-1:0] pr;
    logic                 nz;
    ud_t                  s;
    s  = ud_q[QU];
    nz = (s.c.n == '0);
    for (int i = 0; i < 3; i++) begin
      uv[i] = {1'b0, s.q[i]};
      if (s.neg[i]) begin
        uv[i] = -uv[i];
      end
      if (nz) begin
        g_d.err[i] = sat_w(-SATW'(s.c.d[i]));
      end else begin
        g_d.err[i] = sat_w(SATW'(sat_w(SATW'(uv[i]))) - SATW'(s.c.d[i]));
      end
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        pr = uv[i] * uv[j];
        pr = pr >>> F;
        if (i == j) begin
          pr = ONE_UP - pr;
        end else begin
          pr = -pr;
        end
        g_d.num[i*3+j] = nw_t'(pr[F+2:0]);
      end
    end
    g_d.c = s.c;
  end

  // Divider chain for the projector, one quotient bit per stage
  logic [W:0] jd_v_q;
  jd_t        jd_q [W+1];
  jd_t        jd0_d;

  always_comb begin
    logic [F+2:0] mag;
    jd0_d.c   = g_q.c;
    jd0_d.err = g_q.err;
    jd0_d.q   = '0;
    for (int e = 0; e < 9; e++) begin
      jd0_d.neg[e] = g_q.num[e][F+2];
      mag          = jd0_d.neg[e] ? (F+3)'(-g_q.num[e]) : (F+3)'(g_q.num[e]);
      jd0_d.rem[e] = JW'(mag) << F;
      jd0_d.ovf[e] = jd0_d.rem[e] >= (JW'(g_q.c.n) << W);
    end
  end

  // Stage I: signed, saturated projector
  logic i_v_q;
  i_t   i_q;
  i_t   i_d;

  always_comb begin
    logic signed [W:0] qv;
    jd_t               s;
    s = jd_q[W];
    for (int e = 0; e < 9; e++) begin
      qv = {1'b0, s.q[e]};
      if (s.neg[e]) begin
        qv = -qv;
      end
      if (s.c.n == '0) begin
        i_d.jn[e] = '0;
      end else if (s.ovf[e]) begin
        i_d.jn[e] = s.neg[e] ? VMIN : VMAX;
      end else begin
        i_d.jn[e] = sat_w(SATW'(qv));
      end
    end
    i_d.err = s.err;
    i_d.p   = s.c.p;
    i_d.rot = s.c.rot;
  end

  // Stage J: products for the rotation and landmark blocks
  logic j_v_q;
  j_t   j_q;
  j_t   j_d;

  always_comb begin
    int unsigned c1;
    int unsigned c2;
    for (int i = 0; i < 3; i++) begin
      for (int c = 0; c < 3; c++) begin
        c1 = (c == 2) ? 0 : c + 1;
        c2 = (c == 0) ? 2 : c - 1;
        j_d.ra[i*3+c] = mulq(i_q.jn[i*3+c2], i_q.p[c1]);
        j_d.rb[i*3+c] = mulq(i_q.jn[i*3+c1], i_q.p[c2]);
        for (int k = 0; k < 3; k++) begin
          j_d.lp[(i*3+c)*3+k] = mulq(i_q.jn[i*3+k], i_q.rot[k*3+c]);
        end
      end
    end
    j_d.jn  = i_q.jn;
    j_d.err = i_q.err;
  end

  // Stage K: sums
  k_t k_d;

  always_comb begin
    for (int e = 0; e < 9; e++) begin
      k_d.jr[e] = sat_w(SATW'(j_q.ra[e]) - SATW'(j_q.rb[e]));
      k_d.jl[e] = sat_w(SATW'(j_q.lp[e*3]) + SATW'(j_q.lp[e*3+1]) +
                        SATW'(j_q.lp[e*3+2]));
    end
    k_d.jn  = j_q.jn;
    k_d.err = j_q.err;
  end

  // Pipeline valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q  <= 1'b0;
      b_v_q  <= 1'b0;
      c_v_q  <= 1'b0;
      d_v_q  <= 1'b0;
      sq_v_q <= '0;
      ud_v_q <= '0;
      g_v_q  <= 1'b0;
      jd_v_q <= '0;
      i_v_q  <= 1'b0;
      j_v_q  <= 1'b0;
      k_v_q  <= 1'b0;
    end else if (en) begin
      a_v_q  <= obs_acc && obs_i.data.func == brj_pkg::FUNC_OBS;
      b_v_q  <= a_v_q;
      c_v_q  <= b_v_q;
      d_v_q  <= c_v_q;
      sq_v_q <= {sq_v_q[W-1:0], d_v_q};
      ud_v_q <= {ud_v_q[QU-1:0], sq_v_q[W]};
      g_v_q  <= ud_v_q[QU];
      jd_v_q <= {jd_v_q[W-1:0], g_v_q};
      i_v_q  <= jd_v_q[W];
      j_v_q  <= i_v_q;
      k_v_q  <= j_v_q;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q      <= a_d;
      b_q      <= b_d;
      c_q      <= c_d;
      d_q      <= d_d;
      sq_q[0]  <= sq0_d;
      for (int k = 1; k <= W; k++) begin
        sq_q[k] <= sqrt_step(sq_q[k-1], W - k);
      end
      ud_q[0] <= ud0_d;
      for (int k = 1; k <= QU; k++) begin
        ud_q[k] <= udiv_step(ud_q[k-1], QU - k);
      end
      g_q     <= g_d;
      jd_q[0] <= jd0_d;
      for (int k = 1; k <= W; k++) begin
        jd_q[k] <= jdiv_step(jd_q[k-1], W - k);
      end
      i_q <= i_d;
      j_q <= j_d;
      k_q <= k_d;
    end
  end

  // Row serializer
  logic [1:0] ser_row_d;
  logic       ser_v_d;

  always_comb begin
    ser_v_d   = ser_v_q;
    ser_row_d = ser_row_q;
    if (ser_load) begin
      ser_v_d   = k_v_q;
      ser_row_d = brj_pkg::ROW_FIRST;
    end else if (res_o.ready) begin
      ser_row_d = ser_row_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_v_q   <= 1'b0;
      ser_row_q <= brj_pkg::ROW_FIRST;
    end else begin
      ser_v_q   <= ser_v_d;
      ser_row_q <= ser_row_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ser_load) begin
      ser_q <= k_q;
    end
  end

  always_comb begin
    logic [3:0] base;
    logic [1:0] er;
    case (ser_row_q)
      brj_pkg::ROW_FIRST: begin
        base = 4'd0;
        er   = 2'd0;
      end
      brj_pkg::ROW_MID: begin
        base = 4'd3;
        er   = 2'd1;
      end
      default: begin
        base = 4'd6;
        er   = 2'd2;
      end
    endcase
    res_o.valid          = ser_v_q;
    res_o.data.row_index = ser_row_q;
    res_o.data.err_value = 32'(ser_q.err[er]);
    res_o.data.jac_0     = 32'(ser_q.jn[base]);
    res_o.data.jac_1     = 32'(ser_q.jn[base+4'd1]);
    res_o.data.jac_2     = 32'(ser_q.jn[base+4'd2]);
    res_o.data.jac_3     = 32'(ser_q.jr[base]);
    res_o.data.jac_4     = 32'(ser_q.jr[base+4'd1]);
    res_o.data.jac_5     = 32'(ser_q.jr[base+4'd2]);
    res_o.data.jac_6     = 32'(ser_q.jl[base]);
    res_o.data.jac_7     = 32'(ser_q.jl[base+4'd1]);
    res_o.data.jac_8     = 32'(ser_q.jl[base+4'd2]);
    res_o.data.last_row  = (ser_row_q == brj_pkg::ROW_LAST);
  end

  // Assertions
  a_row_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.ready && ser_row_q != brj_pkg::ROW_LAST) |=>
    (res_o.valid && ser_row_q == $past(ser_row_q) + 2'd1))
    else $error("row serializer skipped or dropped a row");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (k_v_q && !en) |=> k_v_q)
    else $error("last pipeline stage lost an item during a stall");

  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !obs_i.ready |-> (k_v_q && ser_v_q))
    else $error("input held off while the output side had room");

  a_pose_row_three: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (obs_i.valid && obs_i.ready && obs_i.data.func == brj_pkg::FUNC_POSE &&
     obs_i.data.pose_row == brj_pkg::POSE_ROWS) |=> $stable(pose_q))
    else $error("pose store changed on a load of row three");

endmodule
